>>> rtl/per_cpu_page_free_list_allocator_defines.svh
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_defines
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PCPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and constants of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpa_pkg;

	localparam int DIV_W = 32;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/pcpa_div.sv
// ----------------------------------------------------------------------------
// pcpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_div import pcpa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNTW = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNTW-1:0]  cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;

	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_sub;
	logic             ge;
	logic [DIV_W-1:0] rem_nx;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		ge      = (rem_sh >= {1'b0, dvs_q});
		rem_nx  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Per-CPU LIFO page free lists with stealing, over a configured region.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; req_stall is high from acceptance
// until the result is taken into the response register. An alloc is served
// from the requester's own list when it holds a page, else a steal scans
// the other lists' heads in index order; an alloc fails if none has a page.
// A free that passes the range checks gets the per-CPU share from a
// reciprocal multiply by a constant, then the owner index from a 32-step
// pass through the restoring divider, and is pushed on the owner's list.
// A free may instead be rejected by the range checks, for a zero share or
// for an owner index past the last CPU. The response register lets the next
// request be accepted while a result still waits on rsp_stall. Lists start
// empty at reset; the next-page table is not cleared and is filled only by
// frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_cpu_page_free_list_allocator_defines.svh"

module per_cpu_page_free_list_allocator import pcpa_pkg::*; #(
	parameter int CPU_COUNT  = 8,
	parameter int PAGE_COUNT = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	// request channel
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        opcode,
	input  wire logic [2:0]  requester,
	input  wire logic [31:0] free_address,
	// response channel
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       status,
	output logic [31:0]      page_address,
	output logic [2:0]       served_by
);

	localparam int CW  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int IW  = $clog2(PAGE_COUNT);
	localparam int PBW = $clog2(PAGE_BYTES);
	localparam int IXW = DIV_W + 1 - PBW;   // page index width before range check

	// span / CPU_COUNT == (span * SHARE_MUL) >> (32 + SHL) for every 32-bit span
	localparam int SHL = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 0;
	localparam logic [32:0] SHARE_MUL =
		33'(((64'd1 << (32 + SHL)) + 64'(CPU_COUNT - 1)) / 64'(CPU_COUNT));

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_REGION_START = 1'b0;
	localparam logic CFG_REGION_END   = 1'b1;

	localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
	localparam logic [31:0] REGION_END_RST   = 32'h8800_0000;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EMPTY,
		STAT_REJECT
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREE_CHK,
		ST_SHARE,
		ST_DIV_OWNER,
		ST_PUSH,
		ST_ALLOC_OWN,
		ST_SCAN,
		ST_POP_RD,
		ST_POP_WB,
		ST_RESULT
	} state_t;

	state_t           state_q;

	logic [31:0]      start_q;
	logic [31:0]      end_q;

	// list heads: index payload plus a valid bit per CPU
	logic [IW-1:0]    head_idx_q [CPU_COUNT];
	logic [CPU_COUNT-1:0] head_vld_q;

	// current transaction
	logic [31:0]      addr_q;
	logic [2:0]       req_q;
	logic [IW-1:0]    idx_q;
	logic [31:0]      dist_q;
	logic [31:0]      span_q;
	logic [31:0]      share_q;
	logic [IW-1:0]    pop_idx_q;
	logic [CW-1:0]    cur_q;       // list under work: own, scan position or owner
	logic             div_start_q;

	// parked result and response register
	status_t          res_status_q;
	logic [31:0]      res_page_q;
	logic [2:0]       res_served_q;
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic [31:0]      rsp_page_q;
	logic [2:0]       rsp_served_q;

	logic             req_acc;
	logic [32:0]      base33;
	logic [32:0]      diff33;
	logic [IXW-1:0]   idx_full;
	logic             chk_reject;
	logic             own_ok;
	logic [CW-1:0]    req_idx;
	logic             scan_hit;
	logic             scan_last;
	logic [31:0]      pop_page;
	logic [64:0]      share_prod;
	logic [31:0]      share_nx;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic             ram_we;
	logic             ram_re;
	logic [IW:0]      ram_wdata;
	logic [IW:0]      ram_rdata;
	logic [IW-1:0]    ram_raddr;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	// ------------------------------------------------------------------
	// address checks and page numbering
	// ------------------------------------------------------------------
	always_comb begin
		// region start rounded up to a page boundary
		base33   = ({1'b0, start_q} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
		diff33   = {1'b0, addr_q} - base33;
		idx_full = diff33[32:PBW];
		chk_reject = (addr_q[PBW-1:0] != '0) ||
			(addr_q < start_q) ||
			(addr_q >= end_q) ||
			(64'(idx_full) >= 64'(PAGE_COUNT));
		pop_page = base33[31:0] + (32'(pop_idx_q) << PBW);
	end

	// ------------------------------------------------------------------
	// alloc list selection
	// ------------------------------------------------------------------
	always_comb begin
		req_idx   = CW'(req_q);
		own_ok    = (32'(req_q) < 32'(CPU_COUNT)) && head_vld_q[req_idx];
		scan_hit  = (32'(cur_q) != 32'(req_q)) && head_vld_q[cur_q];
		scan_last = (cur_q == CW'(CPU_COUNT - 1));
	end

	// ------------------------------------------------------------------
	// per-CPU share by reciprocal multiply, owner = dist / share on the
	// divider
	// ------------------------------------------------------------------
	always_comb begin
		share_prod = 65'(span_q) * 65'(SHARE_MUL);
		share_nx   = 32'(share_prod >> (32 + SHL));
	end

	always_comb begin
		div_req.start    = div_start_q;
		div_req.dividend = dist_q;
		div_req.divisor  = share_q;
	end

	pcpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// next-page table: push writes old head, pop reads the successor
	// ------------------------------------------------------------------
	assign ram_we    = (state_q == ST_PUSH);
	assign ram_wdata = {head_vld_q[cur_q], head_idx_q[cur_q]};
	assign ram_re    = (state_q == ST_POP_RD);
	assign ram_raddr = head_idx_q[cur_q];

	pcpa_ram #(
		.WIDTH (IW + 1),
		.DEPTH (PAGE_COUNT)
	) u_next_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (idx_q),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= REGION_START_RST;
			end_q   <= REGION_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REGION_START: start_q <= cfg_data;
				CFG_REGION_END:   end_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// transaction data, no reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q <= free_address;
			req_q  <= requester;
		end
		if (state_q == ST_FREE_CHK) begin
			idx_q  <= IW'(idx_full);
			dist_q <= addr_q - start_q;
			span_q <= end_q - start_q;
		end
		if (state_q == ST_SHARE) begin
			share_q <= share_nx;
		end
		if (state_q == ST_POP_RD) begin
			pop_idx_q <= head_idx_q[cur_q];
		end
		if (state_q == ST_POP_WB) begin
			head_idx_q[cur_q] <= ram_rdata[IW-1:0];
		end
		if (state_q == ST_PUSH) begin
			head_idx_q[cur_q] <= idx_q;
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_vld_q   <= '0;
			cur_q        <= '0;
			div_start_q  <= 1'b0;
			res_status_q <= STAT_OK;
			res_page_q   <= '0;
			res_served_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= STAT_OK;
			rsp_page_q   <= '0;
			rsp_served_q <= '0;
		end else begin
			div_start_q <= 1'b0;
			// ST_RESULT reloads the response register itself
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= (opcode == OP_FREE) ? ST_FREE_CHK : ST_ALLOC_OWN;
					end
				end
				ST_FREE_CHK: begin
					if (chk_reject) begin
						res_status_q <= STAT_REJECT;
						res_page_q   <= '0;
						res_served_q <= '0;
						state_q      <= ST_RESULT;
					end else begin
						state_q <= ST_SHARE;
					end
				end
				ST_SHARE: begin
					if (share_nx == '0) begin
						res_status_q <= STAT_REJECT;
						res_page_q   <= '0;
						res_served_q <= '0;
						state_q      <= ST_RESULT;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_OWNER;
					end
				end
				ST_DIV_OWNER: begin
					if (div_rsp.done) begin
						if (div_rsp.quotient >= 32'(CPU_COUNT)) begin
							res_status_q <= STAT_REJECT;
							res_page_q   <= '0;
							res_served_q <= '0;
							state_q      <= ST_RESULT;
						end else begin
							cur_q   <= div_rsp.quotient[CW-1:0];
							state_q <= ST_PUSH;
						end
					end
				end
				ST_PUSH: begin
					head_vld_q[cur_q] <= 1'b1;
					res_status_q      <= STAT_OK;
					res_page_q        <= '0;
					res_served_q      <= 3'(cur_q);
					state_q           <= ST_RESULT;
				end
				ST_ALLOC_OWN: begin
					if (own_ok) begin
						cur_q   <= req_idx;
						state_q <= ST_POP_RD;
					end else begin
						cur_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// steal: first non-empty other list in index order
					if (scan_hit) begin
						state_q <= ST_POP_RD;
					end else if (scan_last) begin
						res_status_q <= STAT_EMPTY;
						res_page_q   <= '0;
						res_served_q <= '0;
						state_q      <= ST_RESULT;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_WB;
				end
				ST_POP_WB: begin
					head_vld_q[cur_q] <= ram_rdata[IW];
					res_status_q      <= STAT_OK;
					res_page_q        <= pop_page;
					res_served_q      <= 3'(cur_q);
					state_q           <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_page_q   <= res_page_q;
						rsp_served_q <= res_served_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign page_address = rsp_page_q;
	assign served_by    = rsp_served_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`PCPA_ASSERT_NXT(a_acc_leaves_idle, req_acc, state_q != ST_IDLE, "accepted request left block idle")
	`PCPA_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy, "divider started while busy")
	`PCPA_ASSERT_NXT(a_push_sets_head, ram_we, head_vld_q[cur_q], "push did not mark list head valid")
	`PCPA_ASSERT_IMP(a_page_aligned, rsp_valid, page_address[PBW-1:0] == '0, "returned page not aligned")
	`PCPA_ASSERT_IMP(a_fail_zero, rsp_valid && (status != STAT_OK), (page_address == '0) && (served_by == '0), "failure result not zeroed")

endmodule

`default_nettype wire

>>> tb/sv/tb_per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// Self-checking bench for the per-CPU page free-list allocator. A scoreboard
// keeps its own copy of the list heads and the page links, works out the
// reply of every accepted request and checks the replies in order. Stimulus
// is a directed pass over the range checks and the region extremes, then
// random alloc/free traffic over two regions with random gaps on both
// channels, one long response hold-off, and a double free at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_per_cpu_page_free_list_allocator;

	localparam int CPU_COUNT    = 8;
	localparam int PAGE_COUNT   = 32768;
	localparam int PAGE_BYTES   = 4096;
	localparam int IDLE_PERCENT = 34;
	localparam int HOLD_CYCLES  = 400;
	// margin after the last reply, well over the time a checked free takes
	localparam int DRAIN_CYCLES = 150;
	localparam int CYCLE_LIMIT  = 600000;

	localparam logic [31:0] RESET_REGION_START = 32'h8000_0000;
	localparam logic [31:0] RESET_REGION_END   = 32'h8800_0000;

	typedef enum logic {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_REJECT = 2'd2} status_t;
	typedef enum logic {REG_REGION_START = 1'b0, REG_REGION_END = 1'b1} reg_t;

	typedef struct {
		status_t     status;
		logic [31:0] page_address;
		logic [2:0]  served_by;
	} page_reply_t;

	// ------------------------------------------------------------------------
	// Scoreboard: mirror of the free lists plus the queue of replies owed.
	// Lists hold page indices; addresses are rebuilt from the current base,
	// so pages survive a region change with their old index.
	// ------------------------------------------------------------------------
	class page_list_scoreboard;
		logic [31:0] region_start;
		logic [31:0] region_end;
		logic [15:0] head_page [CPU_COUNT];
		bit          head_live [CPU_COUNT];
		logic [15:0] link_page [PAGE_COUNT];
		bit          link_live [PAGE_COUNT];
		bit          on_list   [PAGE_COUNT];
		page_reply_t due_replies [$];
		int          mismatches;

		function new();
			region_start = RESET_REGION_START;
			region_end   = RESET_REGION_END;
			foreach (head_live[i]) begin
				head_page[i] = '0;
				head_live[i] = 1'b0;
			end
			foreach (link_live[i]) begin
				link_page[i] = '0;
				link_live[i] = 1'b0;
				on_list[i]   = 1'b0;
			end
			mismatches = 0;
		endfunction

		function void set_region(reg_t which, logic [31:0] value);
			if (which == REG_REGION_START)
				region_start = value;
			else
				region_end = value;
		endfunction

		// region start rounded up to a page; may reach 2^32
		function logic [63:0] page_base();
			logic [63:0] s;
			logic [63:0] rem;
			s   = {32'd0, region_start};
			rem = s % PAGE_BYTES;
			return (rem != 0) ? s + PAGE_BYTES - rem : s;
		endfunction

		function page_reply_t push_page(logic [31:0] addr);
			page_reply_t r;
			logic [63:0] s, e, a, idx, share, owner;
			r.status       = ST_REJECT;
			r.page_address = '0;
			r.served_by    = '0;
			s = {32'd0, region_start};
			e = {32'd0, region_end};
			a = {32'd0, addr};
			if (a % PAGE_BYTES != 0 || a < s || a >= e)
				return r;
			idx = (a - page_base()) / PAGE_BYTES;
			if (idx >= PAGE_COUNT)
				return r;
			share = (e - s) / CPU_COUNT;
			if (share == 0)
				return r;
			owner = (a - s) / share;
			if (owner >= CPU_COUNT)
				return r;
			link_page[idx]   = head_page[owner];
			link_live[idx]   = head_live[owner];
			head_page[owner] = idx[15:0];
			head_live[owner] = 1'b1;
			on_list[idx]     = 1'b1;
			r.status    = ST_OK;
			r.served_by = owner[2:0];
			return r;
		endfunction

		// own list first, else the first non-empty other list by index
		function page_reply_t pop_page(logic [2:0] who);
			page_reply_t r;
			int src;
			logic [63:0] h, addr;
			r.status       = ST_EMPTY;
			r.page_address = '0;
			r.served_by    = '0;
			src = -1;
			if (head_live[who]) begin
				src = who;
			end else begin
				for (int i = 0; i < CPU_COUNT; i++)
					if (src < 0 && i != who && head_live[i])
						src = i;
			end
			if (src < 0)
				return r;
			h = {48'd0, head_page[src]};
			if (link_live[h])
				head_page[src] = link_page[h];
			else
				head_live[src] = 1'b0;
			on_list[h] = 1'b0;
			addr = page_base() + h * PAGE_BYTES;
			r.status       = ST_OK;
			r.page_address = addr[31:0];
			r.served_by    = src[2:0];
			return r;
		endfunction

		function void note_request(op_t op, logic [2:0] who, logic [31:0] addr);
			if (op == OP_FREE)
				due_replies.push_back(push_page(addr));
			else
				due_replies.push_back(pop_page(who));
		endfunction

		function void check_result(logic [1:0] got_status, logic [31:0] got_page,
				logic [2:0] got_cpu);
			page_reply_t want;
			if (due_replies.size() == 0) begin
				$error("reply with nothing outstanding: status %0d page_address %h",
					got_status, got_page);
				mismatches++;
				return;
			end
			want = due_replies.pop_front();
			if (got_status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got_status);
				mismatches++;
			end
			if (got_page !== want.page_address) begin
				$error("page_address: expected %h, got %h", want.page_address, got_page);
				mismatches++;
			end
			if (got_cpu !== want.served_by) begin
				$error("served_by: expected %0d, got %0d", want.served_by, got_cpu);
				mismatches++;
			end
		endfunction

		// true when the page at addr sits on some list right now
		function bit page_held(logic [31:0] addr);
			logic [63:0] a, base, idx;
			a    = {32'd0, addr};
			base = page_base();
			if (a < base)
				return 1'b0;
			idx = (a - base) / PAGE_BYTES;
			if (idx >= PAGE_COUNT)
				return 1'b0;
			return on_list[idx];
		endfunction

		function int outstanding();
			return due_replies.size();
		endfunction

		function bit clean();
			return mismatches == 0 && due_replies.size() == 0;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and its stimulus signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_index    = 1'b0;
	logic [31:0] cfg_data     = '0;
	logic        req_valid    = 1'b0;
	logic        opcode       = 1'b0;
	logic [2:0]  requester    = '0;
	logic [31:0] free_address = '0;
	logic        rsp_stall    = 1'b0;
	logic        cfg_ready;
	logic        req_stall;
	logic        rsp_valid;
	logic [1:0]  status;
	logic [31:0] page_address;
	logic [2:0]  served_by;

	per_cpu_page_free_list_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.opcode       (opcode),
		.requester    (requester),
		.free_address (free_address),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.page_address (page_address),
		.served_by    (served_by)
	);

	page_list_scoreboard sb;
	bit          steady   = 1'b0;  // no idling on either side while set
	bit          hold_ask = 1'b0;  // asks the receiver for a long hold-off
	int unsigned cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_per_cpu_page_free_list_allocator: FAIL");
			$finish;
		end
	end

	function automatic bit roll_idle();
		return !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
	endfunction

	// A page address near the start of a random CPU's share, now and then
	// anywhere in the index space. Aligned, usually inside the region.
	function automatic logic [31:0] likely_page();
		logic [63:0] s, e, share, lo, rem;
		s     = {32'd0, sb.region_start};
		e     = {32'd0, sb.region_end};
		share = (e > s) ? (e - s) / CPU_COUNT : 64'd0;
		lo    = s + $urandom_range(0, CPU_COUNT - 1) * share;
		rem   = lo % PAGE_BYTES;
		if (rem != 0)
			lo = lo + PAGE_BYTES - rem;
		if ($urandom_range(0, 9) == 0)
			lo = lo + $urandom_range(0, PAGE_COUNT - 1) * PAGE_BYTES;
		else
			lo = lo + $urandom_range(0, 15) * PAGE_BYTES;
		return lo[31:0];
	endfunction

	// ------------------------------------------------------------------------
	// Request side: random gaps, payload held until the transaction is taken.
	// The scoreboard learns of the request at the edge that accepts it.
	// ------------------------------------------------------------------------
	task automatic send_request(input op_t op, input logic [2:0] who,
			input logic [31:0] addr);
		while (roll_idle()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		opcode       <= op;
		requester    <= who;
		free_address <= addr;
		do @(posedge clk); while (req_stall);
		sb.note_request(op, who, addr);
	endtask

	// requester is a don't-care on a free, so it gets random bits
	task automatic free_at(input logic [31:0] addr);
		send_request(OP_FREE, 3'($urandom_range(0, CPU_COUNT - 1)), addr);
	endtask

	task automatic alloc_for(input logic [2:0] who);
		send_request(OP_ALLOC, who, $urandom);
	endtask

	// Region writes only with the block idle: no request offered and every
	// reply back (each request yields exactly one reply).
	task automatic write_region(input reg_t which, input logic [31:0] value);
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_region(which, value);
	endtask

	// Mostly well-formed traffic: allocs, frees of pages not on any list,
	// bursts of allocs to empty the lists, and some junk frees.
	task automatic random_run(input int items);
		logic [31:0] a;
		int pick;
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(0, 24) == 0)
				repeat (8) alloc_for(3'($urandom_range(0, CPU_COUNT - 1)));
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				alloc_for(3'($urandom_range(0, CPU_COUNT - 1)));
			end else if (pick < 88) begin
				// avoid a double free here; it would loop a list for good
				a = likely_page();
				for (int t = 0; t < 8 && sb.page_held(a); t++)
					a = likely_page();
				if (sb.page_held(a))
					alloc_for(3'($urandom_range(0, CPU_COUNT - 1)));
				else
					free_at(a);
			end else begin
				case ($urandom_range(0, 3))
					0: a = likely_page() | 32'($urandom_range(1, PAGE_BYTES - 1));
					1: a = $urandom;
					2: a = sb.region_start - 32'($urandom_range(1, 4) * PAGE_BYTES);
					default: a = sb.region_end + 32'($urandom_range(0, 4) * PAGE_BYTES);
				endcase
				free_at(a);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side: checks each accepted transaction and stalls at random,
	// or for a long counted stretch when asked.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_result(status, page_address, served_by);
			if (hold_ask) begin
				hold_ask  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= roll_idle();
			end
		end
	end

	initial begin : stimulus
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default region 0x8000_0000..0x8800_0000, 16 MiB share per CPU
		alloc_for(3'd0);            // all lists empty after reset
		free_at(32'h8000_0000);     // first page, CPU 0
		free_at(32'h87FF_F000);     // last page, CPU 7
		free_at(32'h8800_0000);     // at region end
		free_at(32'h7FFF_F000);     // below region start
		free_at(32'h8000_0800);     // misaligned
		free_at(32'h8100_0000);
		free_at(32'h8100_1000);
		alloc_for(3'd1);            // own list, LIFO order
		alloc_for(3'd3);            // steals from CPU 0
		alloc_for(3'd5);            // CPU 0 now empty, steals from CPU 1

		// tiny region whose share does not divide it: last page owner is 8
		write_region(REG_REGION_START, 32'h0000_0000);
		write_region(REG_REGION_END, 32'h0000_1007);
		free_at(32'h0000_1000);     // owner index past the CPU count
		free_at(32'h0000_0000);
		alloc_for(3'd7);            // old page 32767 rebuilt from base 0

		// region narrower than the CPU count: zero share
		write_region(REG_REGION_START, 32'h0000_5000);
		write_region(REG_REGION_END, 32'h0000_5004);
		free_at(32'h0000_5000);

		// full address space: page index runs past the table
		write_region(REG_REGION_START, 32'h0000_0000);
		write_region(REG_REGION_END, 32'hFFFF_FFFF);
		free_at(32'h0800_0000);
		free_at(32'h07FF_F000);
		free_at(32'hFFFF_F000);

		// start just past the top page: base rounds up to 2^32 and wraps
		write_region(REG_REGION_START, 32'hFFFF_F001);
		free_at(32'hFFFF_F000);     // below start
		alloc_for(3'd2);
		alloc_for(3'd0);            // page 0 comes back as address zero
		alloc_for(3'd6);            // empty again

		write_region(REG_REGION_START, RESET_REGION_START);
		write_region(REG_REGION_END, RESET_REGION_END);

		// quiet stretch first, then random gaps plus the long hold-off while
		// requests keep coming so the block backs up into req_stall
		steady = 1'b1;
		random_run(60);
		steady   = 1'b0;
		hold_ask = 1'b1;
		random_run(210);

		// small region with an unaligned start: 128 pages, 16 per CPU, so
		// lists run dry often; old pages from above are rebuilt on this base
		write_region(REG_REGION_START, 32'h1000_0800);
		write_region(REG_REGION_END, 32'h1008_0800);
		random_run(280);

		// double free at the very end: CPU 0's list turns into a loop
		free_at(32'h1000_1000);
		free_at(32'h1000_1000);
		alloc_for(3'd0);
		alloc_for(3'd0);
		alloc_for(3'd4);

		req_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.clean())
			$display("tb_per_cpu_page_free_list_allocator: PASS");
		else
			$display("tb_per_cpu_page_free_list_allocator: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> per_cpu_page_free_list_allocator.f
+incdir+rtl
rtl/pcpa_pkg.sv
rtl/pcpa_ram.sv
rtl/pcpa_div.sv
rtl/per_cpu_page_free_list_allocator.sv
tb/sv/tb_per_cpu_page_free_list_allocator.sv
